@@ hw/rtl/vsm_pkg.sv @@
package vsm_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [3:0] CMD_RESERVE    = 4'd0;
  localparam logic [3:0] CMD_PLAY       = 4'd1;
  localparam logic [3:0] CMD_UPDATE     = 4'd2;
  localparam logic [3:0] CMD_STOP       = 4'd3;
  localparam logic [3:0] CMD_STOP_ALL   = 4'd4;
  localparam logic [3:0] CMD_PAUSE_ALL  = 4'd5;
  localparam logic [3:0] CMD_UNPAUSE    = 4'd6;
  localparam logic [3:0] CMD_MIX        = 4'd7;
  localparam logic [3:0] CMD_LOAD       = 4'd8;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_STALE   = 2'd2;

  localparam logic [16:0] MAX_REGION = 17'd65536;

  // Division by the unity gain of 10000 as a reciprocal multiply:
  // ceil(2^44 / 10000), exact for magnitudes below 2^30.
  localparam int          RECIP_SHIFT = 44;
  localparam logic [30:0] RECIP_GAIN  = 31'd1759218605;

  typedef enum logic [3:0] {
    OP_RESERVE,
    OP_PLAY,
    OP_UPDATE,
    OP_STOP,
    OP_STOP_ALL,
    OP_PAUSE_ALL,
    OP_UNPAUSE_ALL,
    OP_MIX,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               idx_ok;
    logic [6:0]         idx;
    logic [31:0]        gen;
    logic [15:0]        start;
    logic [16:0]        length;
    logic [13:0]        gain_l;
    logic [13:0]        gain_r;
    logic               rep;
    logic               chan;
    logic [15:0]        laddr;
    logic signed [15:0] lval;
  } item_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [15:0] pos;
    logic [15:0] start;
    logic [16:0] length;
    logic [13:0] gain_l;
    logic [13:0] gain_r;
  } slot_t;

endpackage

@@ hw/rtl/vsm_ram.sv @@
module vsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/vsm_front.sv @@
module vsm_front import vsm_pkg::*; #(
  parameter int VOICE_SLOTS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic [6:0]         in_slot_index,
  input  logic [31:0]        in_slot_generation,
  input  logic [15:0]        in_region_start,
  input  logic [16:0]        in_region_length,
  input  logic [13:0]        in_volume_left,
  input  logic [13:0]        in_volume_right,
  input  logic               in_repeat_flag,
  input  logic               in_channel_select,
  input  logic [15:0]        in_load_address,
  input  logic signed [15:0] in_load_value,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_take
);

  item_t      fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  item_t      item;
  logic       push;
  logic       pop;

  // Decode the command and clamp the region length before queueing.
  always_comb begin
    item = '0;
    case (in_cmd)
      CMD_RESERVE:   item.op = OP_RESERVE;
      CMD_PLAY:      item.op = OP_PLAY;
      CMD_UPDATE:    item.op = OP_UPDATE;
      CMD_STOP:      item.op = OP_STOP;
      CMD_STOP_ALL:  item.op = OP_STOP_ALL;
      CMD_PAUSE_ALL: item.op = OP_PAUSE_ALL;
      CMD_UNPAUSE:   item.op = OP_UNPAUSE_ALL;
      CMD_MIX:       item.op = OP_MIX;
      CMD_LOAD:      item.op = OP_LOAD;
      default:       item.op = OP_NOP;
    endcase
    item.idx_ok = (32'(in_slot_index) < VOICE_SLOTS);
    item.idx    = in_slot_index;
    item.gen    = in_slot_generation;
    item.start  = in_region_start;
    item.length = (in_region_length > MAX_REGION) ? MAX_REGION : in_region_length;
    item.gain_l = in_volume_left;
    item.gain_r = in_volume_right;
    item.rep    = in_repeat_flag;
    item.chan   = in_channel_select;
    item.laddr  = in_load_address;
    item.lval   = in_load_value;
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/vsm_back.sv @@
module vsm_back import vsm_pkg::*; #(
  parameter int VOICE_SLOTS  = 128,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_handle_index,
  output logic [31:0]        out_handle_generation,
  output logic signed [15:0] out_mixed_sample
);

  localparam int SW = $clog2(VOICE_SLOTS);
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam logic [SW-1:0] LAST = SW'(VOICE_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_RES_SCAN, S_RES_RD, S_WALK, S_KILL,
    S_MIX_RD, S_MIX_MUL, S_MIX_DIV, S_MIX_ACC, S_RESULT
  } state_t;

  state_t                 state_r;
  item_t                  it_r;
  logic [SW-1:0]          cnt_r;
  logic [SW-1:0]          cur_r;
  logic [VOICE_SLOTS-1:0] vld_r, reserved_r, alive_r, paused_r, repeat_r;
  logic [1:0]             status_r;
  logic [6:0]             hidx_r;
  logic [31:0]            hgen_r;
  logic signed [31:0]     acc_r;
  logic [13:0]            gain_r;
  logic [29:0]            mag_r;
  logic                   neg_r;
  logic [60:0]            quo_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [6:0]             out_hidx_r;
  logic [31:0]            out_hgen_r;
  logic signed [15:0]     out_mixed_r;

  logic [$bits(slot_t)-1:0] slot_rdata;
  logic [SW-1:0]            slot_raddr;
  logic                     slot_we;
  slot_t                    slot_wdata;
  slot_t                    sd;
  logic [15:0]              smp_rdata;
  logic [AW-1:0]            smp_raddr;
  logic [AW-1:0]            smp_waddr;
  logic                     smp_we;

  logic [SW-1:0]        q_idx;
  logic                 gen_match;
  logic [16:0]          next_pos;
  logic                 at_end;
  logic [16:0]          smp_sum;
  logic [AW+16:0]       smp_sum_x;
  logic [AW+15:0]       load_x;
  logic signed [30:0]   prod;
  logic signed [31:0]   sat_in;
  logic signed [15:0]   mixed;
  logic                 walk_active;
  logic                 out_free;
  logic                 slot_op;

  vsm_ram #(.WIDTH($bits(slot_t)), .DEPTH(VOICE_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (cur_r),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  vsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (q_item.lval),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // A slot never written reads as all zero.
  assign sd        = vld_r[cur_r] ? slot_t'(slot_rdata) : '0;
  assign q_idx     = SW'({{SW{1'b0}}, q_item.idx});
  assign gen_match = (sd.gen == it_r.gen);
  assign next_pos  = {1'b0, sd.pos} + 17'd1;
  assign at_end    = (next_pos >= sd.length);
  assign smp_sum   = {1'b0, sd.start} + {1'b0, sd.pos};
  assign smp_sum_x = {{AW{1'b0}}, smp_sum};
  assign smp_raddr = smp_sum_x[AW-1:0];
  assign load_x    = {{AW{1'b0}}, q_item.laddr};
  assign smp_waddr = load_x[AW-1:0];
  assign prod      = $signed(smp_rdata) * $signed({1'b0, gain_r});
  assign out_free  = !out_valid_r || !out_stall;
  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign smp_we    = q_take && (q_item.op == OP_LOAD);
  assign slot_op   = (q_item.op == OP_PLAY) || (q_item.op == OP_UPDATE) ||
                     (q_item.op == OP_STOP);

  assign walk_active = (it_r.op == OP_MIX) ? (alive_r[cnt_r] && !paused_r[cnt_r])
                                           : alive_r[cnt_r];

  assign sat_in = acc_r;
  always_comb begin
    if (sat_in > 32'sd32767) begin
      mixed = 16'sd32767;
    end else if (sat_in < -32'sd32768) begin
      mixed = -16'sd32768;
    end else begin
      mixed = sat_in[15:0];
    end
  end

  // Slot memory ports: each read address is presented in the state before the one that uses the data.
  always_comb begin
    slot_raddr = cnt_r;
    slot_we    = 1'b0;
    slot_wdata = sd;
    case (state_r)
      S_IDLE: begin
        slot_raddr = q_idx;
      end
      S_SLOT: begin
        if (it_r.op == OP_PLAY) begin
          slot_we           = 1'b1;
          slot_wdata.pos    = '0;
          slot_wdata.start  = it_r.start;
          slot_wdata.length = it_r.length;
          slot_wdata.gain_l = it_r.gain_l;
          slot_wdata.gain_r = it_r.gain_r;
        end else if (gen_match) begin
          slot_we = 1'b1;
          if (it_r.op == OP_UPDATE) begin
            slot_wdata.gain_l = it_r.gain_l;
            slot_wdata.gain_r = it_r.gain_r;
          end else begin
            slot_wdata.gen = sd.gen + 32'd1;
          end
        end
      end
      S_KILL: begin
        slot_we        = 1'b1;
        slot_wdata.gen = sd.gen + 32'd1;
      end
      S_MIX_RD: begin
        slot_we = 1'b1;
        if (at_end && repeat_r[cur_r]) begin
          slot_wdata.pos = '0;
        end else begin
          slot_wdata.pos = next_pos[15:0];
        end
        if (at_end && !repeat_r[cur_r]) begin
          slot_wdata.gen = sd.gen + 32'd1;
        end
      end
      default: begin
        slot_raddr = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      reserved_r  <= '0;
      alive_r     <= '0;
      paused_r    <= '0;
      repeat_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r     <= q_item;
            cnt_r    <= '0;
            cur_r    <= q_idx;
            status_r <= (slot_op && !q_item.idx_ok) ? ST_STALE : ST_DONE;
            hidx_r   <= '0;
            hgen_r   <= '0;
            acc_r    <= '0;
            case (q_item.op)
              OP_RESERVE:     state_r  <= S_RES_SCAN;
              OP_PLAY, OP_UPDATE, OP_STOP: begin
                if (q_item.idx_ok) begin
                  state_r <= S_SLOT;
                end else begin
                  state_r <= S_RESULT;
                end
              end
              OP_STOP_ALL, OP_MIX: state_r <= S_WALK;
              OP_PAUSE_ALL: begin
                paused_r <= '1;
                state_r  <= S_RESULT;
              end
              OP_UNPAUSE_ALL: begin
                paused_r <= '0;
                state_r  <= S_RESULT;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_SLOT: begin
          state_r <= S_RESULT;
          if (it_r.op == OP_PLAY) begin
            vld_r[cur_r]    <= 1'b1;
            alive_r[cur_r]  <= 1'b1;
            paused_r[cur_r] <= 1'b0;
            repeat_r[cur_r] <= it_r.rep;
          end else if (!gen_match) begin
            status_r <= ST_STALE;
          end else if (it_r.op == OP_UPDATE) begin
            vld_r[cur_r]    <= 1'b1;
            repeat_r[cur_r] <= it_r.rep;
          end else begin
            vld_r[cur_r]      <= 1'b1;
            alive_r[cur_r]    <= 1'b0;
            reserved_r[cur_r] <= 1'b0;
          end
        end
        S_RES_SCAN: begin
          if (!reserved_r[cnt_r]) begin
            cur_r   <= cnt_r;
            state_r <= S_RES_RD;
          end else if (cnt_r == LAST) begin
            status_r <= ST_NO_FREE;
            state_r  <= S_RESULT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RES_RD: begin
          reserved_r[cur_r] <= 1'b1;
          hidx_r            <= 7'({{7{1'b0}}, cur_r});
          hgen_r            <= sd.gen;
          state_r           <= S_RESULT;
        end
        S_WALK: begin
          if (walk_active) begin
            cur_r   <= cnt_r;
            state_r <= (it_r.op == OP_MIX) ? S_MIX_RD : S_KILL;
          end else if (cnt_r == LAST) begin
            state_r <= S_RESULT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_KILL: begin
          vld_r[cur_r]      <= 1'b1;
          alive_r[cur_r]    <= 1'b0;
          reserved_r[cur_r] <= 1'b0;
          if (cnt_r == LAST) begin
            state_r <= S_RESULT;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_WALK;
          end
        end
        S_MIX_RD: begin
          vld_r[cur_r] <= 1'b1;
          if (at_end && !repeat_r[cur_r]) begin
            alive_r[cur_r]    <= 1'b0;
            reserved_r[cur_r] <= 1'b0;
          end
          gain_r  <= it_r.chan ? sd.gain_r : sd.gain_l;
          state_r <= S_MIX_MUL;
        end
        S_MIX_MUL: begin
          neg_r   <= prod[30];
          mag_r   <= prod[30] ? 30'(-prod) : prod[29:0];
          state_r <= S_MIX_DIV;
        end
        S_MIX_DIV: begin
          quo_r   <= mag_r * RECIP_GAIN;
          state_r <= S_MIX_ACC;
        end
        S_MIX_ACC: begin
          if (neg_r) begin
            acc_r <= acc_r - 32'($unsigned(quo_r[60:RECIP_SHIFT]));
          end else begin
            acc_r <= acc_r + 32'($unsigned(quo_r[60:RECIP_SHIFT]));
          end
          if (cnt_r == LAST) begin
            state_r <= S_RESULT;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_WALK;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_hidx_r   <= hidx_r;
            out_hgen_r   <= hgen_r;
            out_mixed_r  <= (it_r.op == OP_MIX) ? mixed : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_index      = out_hidx_r;
  assign out_handle_generation = out_hgen_r;
  assign out_mixed_sample      = out_mixed_r;

endmodule

@@ hw/rtl/voice_slot_mixer_core.sv @@
// Flow: load, pause all, unpause all and unknown commands go straight to the result;
// play, update and stop read their slot and then update it; reserve scans the slots
// for a free one; stop all and mix walk every slot, with extra work for each live voice
// (each live, unpaused voice for mix). Throughput is one transaction at a time in the
// execution unit, with a two-entry queue in front of it.
// Reset (rst_n low, synchronous) clears all slot flags; the sample memory holds garbage.
module voice_slot_mixer_core import vsm_pkg::*; #(
  parameter int VOICE_SLOTS  = 128,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic [6:0]         in_slot_index,
  input  logic [31:0]        in_slot_generation,
  input  logic [15:0]        in_region_start,
  input  logic [16:0]        in_region_length,
  input  logic [13:0]        in_volume_left,
  input  logic [13:0]        in_volume_right,
  input  logic               in_repeat_flag,
  input  logic               in_channel_select,
  input  logic [15:0]        in_load_address,
  input  logic signed [15:0] in_load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [6:0]         out_handle_index,
  output logic [31:0]        out_handle_generation,
  output logic signed [15:0] out_mixed_sample
);

  // The front end decodes each incoming transaction and queues it. The queue holds
  // two entries, so the source can push until it fills while a long mix or scan runs.
  item_t q_item;
  logic  q_valid;
  logic  q_take;

  vsm_front #(.VOICE_SLOTS(VOICE_SLOTS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_slot_index      (in_slot_index),
    .in_slot_generation (in_slot_generation),
    .in_region_start    (in_region_start),
    .in_region_length   (in_region_length),
    .in_volume_left     (in_volume_left),
    .in_volume_right    (in_volume_right),
    .in_repeat_flag     (in_repeat_flag),
    .in_channel_select  (in_channel_select),
    .in_load_address    (in_load_address),
    .in_load_value      (in_load_value),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_take             (q_take)
  );

  // The back end owns the slot table and the sample memory. It walks the slots
  // one per cycle but stops at each live voice; mix runs each live, unpaused voice
  // through a multiply, a reciprocal divide and an accumulate, then registers the result.
  vsm_back #(.VOICE_SLOTS(VOICE_SLOTS), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_take                (q_take),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_handle_index      (out_handle_index),
    .out_handle_generation (out_handle_generation),
    .out_mixed_sample      (out_mixed_sample)
  );

endmodule
